[design/apc_pkg.sv]
package apc_pkg;

  localparam int NUM_SUBJECTS  = 64;
  localparam int NUM_OBJECTS   = 64;
  localparam int CATEGORY_BITS = 32;
  localparam int LEVEL_BITS    = 8;
  localparam int IDX_W         = 6;
  localparam int NAME_W        = 8;
  localparam int MODEL_W       = 3;

  // op codes
  localparam logic [1:0] OP_LOAD_SUBJ = 2'd0;
  localparam logic [1:0] OP_LOAD_OBJ  = 2'd1;
  localparam logic [1:0] OP_RIGHTS    = 2'd2;
  localparam logic [1:0] OP_REQUEST   = 2'd3;

  // access model codes
  localparam logic [2:0] MODEL_BLP      = 3'd0;
  localparam logic [2:0] MODEL_BIBA     = 3'd1;
  localparam logic [2:0] MODEL_BLP_BIBA = 3'd2;
  localparam logic [2:0] MODEL_LWM      = 3'd3;
  localparam logic [2:0] MODEL_WALL     = 3'd4;

  // conflict kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_CLASS = 2'd1;
  localparam logic [1:0] KIND_LEAK  = 2'd2;

  // rights bits
  localparam logic [1:0] RIGHT_READ  = 2'b01;
  localparam logic [1:0] RIGHT_WRITE = 2'b10;

  typedef struct packed {
    logic                     op_subj;
    logic                     op_obj;
    logic                     op_rights;
    logic                     op_req;
    logic [1:0]               need;
    logic [IDX_W-1:0]         subj;
    logic [IDX_W-1:0]         obj;
    logic                     is_write;
    logic [LEVEL_BITS-1:0]    level;
    logic [CATEGORY_BITS-1:0] cats;
    logic [NAME_W-1:0]        company;
    logic [NAME_W-1:0]        cls;
    logic [1:0]               rights;
  } item_t;

  typedef struct packed {
    logic blp;
    logic biba;
    logic lwm;
    logic wall;
  } model_t;

  function automatic model_t model_bits(input logic [MODEL_W-1:0] m);
    model_t r;
    r = '0;
    case (m)
      MODEL_BLP:      r.blp = 1'b1;
      MODEL_BIBA:     r.biba = 1'b1;
      MODEL_BLP_BIBA: begin
        r.blp  = 1'b1;
        r.biba = 1'b1;
      end
      MODEL_LWM: begin
        r.biba = 1'b1;
        r.lwm  = 1'b1;
      end
      MODEL_WALL:     r.wall = 1'b1;
      default:        r = '0;
    endcase
    return r;
  endfunction

  function automatic logic dominates(input logic [LEVEL_BITS-1:0] la,
                                     input logic [CATEGORY_BITS-1:0] ca,
                                     input logic [LEVEL_BITS-1:0] lb,
                                     input logic [CATEGORY_BITS-1:0] cb);
    return (la >= lb) && ((ca & cb) == cb);
  endfunction

endpackage

[design/apc_front.sv]
module apc_front (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_op,
  input  logic [apc_pkg::IDX_W-1:0]           in_subject_index,
  input  logic [apc_pkg::IDX_W-1:0]           in_object_index,
  input  logic                                in_is_write,
  input  logic [apc_pkg::LEVEL_BITS-1:0]      in_level,
  input  logic [apc_pkg::CATEGORY_BITS-1:0]   in_categories,
  input  logic [apc_pkg::NAME_W-1:0]          in_company,
  input  logic [apc_pkg::NAME_W-1:0]          in_conflict_class,
  input  logic [1:0]                          in_rights,
  input  logic                                q_full,
  output logic                                q_push,
  output apc_pkg::item_t                      q_item
);

  // accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // classify the item
  always_comb begin
    q_item           = '0;
    q_item.op_subj   = (in_op == apc_pkg::OP_LOAD_SUBJ);
    q_item.op_obj    = (in_op == apc_pkg::OP_LOAD_OBJ);
    q_item.op_rights = (in_op == apc_pkg::OP_RIGHTS);
    q_item.op_req    = (in_op == apc_pkg::OP_REQUEST);
    q_item.need      = in_is_write ? apc_pkg::RIGHT_WRITE : apc_pkg::RIGHT_READ;
    q_item.subj      = in_subject_index;
    q_item.obj       = in_object_index;
    q_item.is_write  = in_is_write;
    q_item.level     = in_level;
    q_item.cats      = in_categories;
    q_item.company   = in_company;
    q_item.cls       = in_conflict_class;
    q_item.rights    = in_rights;
  end

endmodule

[design/apc_queue.sv]
module apc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  apc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output apc_pkg::item_t pop_item
);

  localparam int DEPTH = 4;

  apc_pkg::item_t slot_r [DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;

  assign full      = (count_r == 3'(DEPTH));
  assign pop_valid = (count_r != 3'd0);
  assign pop_item  = slot_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = wr_ptr_r + 2'd1;
    if (pop)  rd_ptr_nxt = rd_ptr_r + 2'd1;
    if (push && !pop) count_nxt = count_r + 3'd1;
    else if (!push && pop) count_nxt = count_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

[design/apc_back.sv]
module apc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [apc_pkg::MODEL_W-1:0]       cfg_wdata,
  input  logic                              q_valid,
  input  apc_pkg::item_t                    q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_allowed,
  output logic                              out_dac_ok,
  output logic                              out_blp_ok,
  output logic                              out_biba_ok,
  output logic                              out_wall_ok,
  output logic                              out_status,
  output logic [1:0]                        out_conflict_kind,
  output logic [apc_pkg::IDX_W-1:0]         out_conflict_object,
  output logic                              out_level_lowered,
  output logic [apc_pkg::LEVEL_BITS-1:0]    out_subject_level_now
);

  localparam int LB  = apc_pkg::LEVEL_BITS;
  localparam int CB  = apc_pkg::CATEGORY_BITS;
  localparam int IW  = apc_pkg::IDX_W;
  localparam int NW  = apc_pkg::NAME_W;
  localparam int NS  = apc_pkg::NUM_SUBJECTS;
  localparam int NO  = apc_pkg::NUM_OBJECTS;
  localparam int SW  = LB + CB;
  localparam int OW  = LB + CB + NW + NW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [apc_pkg::MODEL_W-1:0] model_r;
  apc_pkg::model_t mb;
  apc_pkg::item_t item_r;

  // label and history memories
  logic [SW-1:0]   subj_mem [NS];
  logic [OW-1:0]   obj_mem  [NO];
  logic [NO-1:0]   hist_mem [NS];
  logic [2*NO-1:0] rts_mem  [NS];
  logic [SW-1:0]   subj_q;
  logic [OW-1:0]   obj_q;
  logic [NO-1:0]   hist_q;
  logic [2*NO-1:0] rts_q;

  logic [NS-1:0] subj_valid_r;
  logic [NO-1:0] obj_valid_r;
  logic [NS-1:0] rts_row_valid_r;

  logic [IW-1:0] subj_raddr, obj_raddr;
  logic          subj_we, obj_we, hist_we, rts_we;
  logic [SW-1:0] subj_wdata;
  logic [NO-1:0] hist_wdata;
  logic [2*NO-1:0] rts_wdata;

  // latched request operands
  logic [LB-1:0] s_lev_r, o_lev_r;
  logic [CB-1:0] s_cat_r, o_cat_r;
  logic [NW-1:0] o_comp_r, o_cls_r;
  logic [NO-1:0] hist_r;
  logic          ok_r, s_ok_r, dac_r, blp_r, biba_r;
  logic [IW-1:0] j_r;
  logic          f1_r, f2_r;
  logic [IW-1:0] f1j_r, f2j_r;

  // memory output fields
  logic [LB-1:0] sq_lev, oq_lev;
  logic [CB-1:0] sq_cat, oq_cat;
  logic [NW-1:0] oq_comp, oq_cls;
  logic          s_ok, o_ok, dac_now;
  logic [1:0]    rts_cell;

  // scan and finish terms
  logic          counts, hit1, hit2;
  logic          wall, mac, all, lower;
  logic [LB-1:0] min_lev;
  logic          fin_go;

  assign mb = apc_pkg::model_bits(model_r);
  assign {sq_lev, sq_cat} = subj_q;
  assign {oq_lev, oq_cat, oq_comp, oq_cls} = obj_q;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r <= apc_pkg::MODEL_BLP;
    end else if (cfg_we && cfg_wdata <= apc_pkg::MODEL_WALL) begin
      model_r <= cfg_wdata;
    end
  end

  // read addresses
  always_comb begin
    subj_raddr = (state_r == ST_IDLE) ? q_item.subj : item_r.subj;
    case (state_r)
      ST_IDLE: obj_raddr = q_item.obj;
      ST_RD:   obj_raddr = '0;
      ST_SCAN: obj_raddr = j_r + IW'(1);
      default: obj_raddr = item_r.obj;
    endcase
  end

  // operand terms seen in the read stage
  always_comb begin
    s_ok     = subj_valid_r[item_r.subj];
    o_ok     = obj_valid_r[item_r.obj];
    rts_cell = rts_row_valid_r[item_r.subj] ? rts_q[{item_r.obj, 1'b0} +: 2] : 2'b00;
    dac_now  = (rts_cell & item_r.need) != 2'b00;
  end

  // scan comparisons on the object streamed out of memory
  always_comb begin
    counts = hist_r[j_r] && obj_valid_r[j_r] && (oq_cls != '0);
    hit1   = counts && (oq_cls == o_cls_r) && (oq_comp != o_comp_r);
    hit2   = counts && (oq_comp != o_comp_r);
  end

  // decision at the end of a request
  always_comb begin
    wall = !(f1_r || (item_r.is_write && f2_r));
    mac  = (!mb.blp || blp_r) && (!mb.biba || biba_r) && (!mb.wall || wall);
    all  = ok_r && dac_r && mac;
    lower = all && mb.lwm && !item_r.is_write &&
            !apc_pkg::dominates(o_lev_r, o_cat_r, s_lev_r, s_cat_r);
    min_lev = (s_lev_r < o_lev_r) ? s_lev_r : o_lev_r;
    fin_go  = (state_r == ST_FIN) && (!out_valid || out_ready);
  end

  // memory writes
  always_comb begin
    subj_we    = 1'b0;
    subj_wdata = {item_r.level, item_r.cats};
    hist_we    = 1'b0;
    hist_wdata = '0;
    obj_we     = (state_r == ST_RD) && item_r.op_obj;
    rts_we     = (state_r == ST_RD) && item_r.op_rights && s_ok && o_ok;
    rts_wdata  = rts_row_valid_r[item_r.subj] ? rts_q : '0;
    rts_wdata[{item_r.obj, 1'b0} +: 2] = rts_cell | item_r.rights;
    if (state_r == ST_RD && item_r.op_subj) begin
      subj_we = 1'b1;
      hist_we = 1'b1;
    end else if (fin_go && item_r.op_req) begin
      subj_we    = lower;
      subj_wdata = {min_lev, s_cat_r & o_cat_r};
      hist_we    = all && mb.wall && !item_r.is_write;
      hist_wdata = hist_r | (NO'(1) << item_r.obj);
    end
  end

  always_ff @(posedge clk) begin
    if (subj_we) subj_mem[item_r.subj] <= subj_wdata;
    subj_q <= subj_mem[subj_raddr];
  end

  always_ff @(posedge clk) begin
    if (obj_we) obj_mem[item_r.obj] <= {item_r.level, item_r.cats, item_r.company, item_r.cls};
    obj_q <= obj_mem[obj_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[item_r.subj] <= hist_wdata;
    hist_q <= hist_mem[subj_raddr];
  end

  always_ff @(posedge clk) begin
    if (rts_we) rts_mem[item_r.subj] <= rts_wdata;
    rts_q <= rts_mem[subj_raddr];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subj_valid_r    <= '0;
      obj_valid_r     <= '0;
      rts_row_valid_r <= '0;
    end else begin
      if (subj_we && state_r == ST_RD) subj_valid_r[item_r.subj] <= 1'b1;
      if (obj_we) obj_valid_r[item_r.obj] <= 1'b1;
      if (rts_we) rts_row_valid_r[item_r.subj] <= 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (item_r.op_req && s_ok && o_ok && mb.wall) state_nxt = ST_SCAN;
        else state_nxt = ST_FIN;
      end
      ST_SCAN: begin
        if (j_r == IW'(NO - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // operand and scan registers
  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_item;
    if (state_r == ST_RD) begin
      s_lev_r  <= sq_lev;
      s_cat_r  <= sq_cat;
      o_lev_r  <= oq_lev;
      o_cat_r  <= oq_cat;
      o_comp_r <= oq_comp;
      o_cls_r  <= oq_cls;
      hist_r   <= hist_q;
      s_ok_r   <= s_ok;
      ok_r     <= s_ok && o_ok;
      dac_r    <= dac_now;
      blp_r    <= item_r.is_write ? apc_pkg::dominates(oq_lev, oq_cat, sq_lev, sq_cat)
                                  : apc_pkg::dominates(sq_lev, sq_cat, oq_lev, oq_cat);
      biba_r   <= (mb.lwm && !item_r.is_write) ? 1'b1 :
                  item_r.is_write ? apc_pkg::dominates(sq_lev, sq_cat, oq_lev, oq_cat)
                                  : apc_pkg::dominates(oq_lev, oq_cat, sq_lev, sq_cat);
      j_r      <= '0;
      f1_r     <= 1'b0;
      f2_r     <= 1'b0;
      f1j_r    <= '0;
      f2j_r    <= '0;
    end else if (state_r == ST_SCAN) begin
      j_r <= j_r + IW'(1);
      if (hit1 && !f1_r) begin
        f1_r  <= 1'b1;
        f1j_r <= j_r;
      end
      if (hit2 && !f2_r) begin
        f2_r  <= 1'b1;
        f2j_r <= j_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_allowed         <= 1'b0;
      out_dac_ok          <= 1'b0;
      out_blp_ok          <= 1'b0;
      out_biba_ok         <= 1'b0;
      out_wall_ok         <= 1'b0;
      out_conflict_kind   <= apc_pkg::KIND_NONE;
      out_conflict_object <= '0;
      out_level_lowered   <= 1'b0;
      out_status          <= !(item_r.op_subj || item_r.op_obj || ok_r);
      out_subject_level_now <= item_r.op_subj ? item_r.level : (s_ok_r ? s_lev_r : '0);
      if (item_r.op_req && ok_r) begin
        out_allowed       <= all;
        out_dac_ok        <= dac_r;
        out_blp_ok        <= blp_r;
        out_biba_ok       <= biba_r;
        out_wall_ok       <= wall;
        out_level_lowered <= lower;
        if (lower) out_subject_level_now <= min_lev;
        if (f1_r) begin
          out_conflict_kind   <= apc_pkg::KIND_CLASS;
          out_conflict_object <= f1j_r;
        end else if (item_r.is_write && f2_r) begin
          out_conflict_kind   <= apc_pkg::KIND_LEAK;
          out_conflict_object <= f2j_r;
        end
      end
    end
  end

endmodule

[design/access_policy_checker_unit.sv]
// access policy checker: reference monitor over subject and object labels
// and a two-bit rights matrix.
// input channel in_valid/in_ready carries one item: a label load, a rights
// add or an access request. the result channel out_valid/out_ready returns
// exactly one result item per input item, in order.
// cfg_we/cfg_wdata writes the access model; values above four are ignored.
// a front stage accepts and classifies items into a four-entry queue; a back
// sequencer reads the label memories, runs the checks and writes back.
// loads and requests outside the chinese wall model pass the back's read,
// decide and deliver steps; a chinese wall request on a loaded subject and
// object adds a walk over all 64 object entries, one per cycle.
// the front keeps accepting while the queue has room, so items queue up
// while the back works or while the receiver stalls.
// a stalled result sits in the output register; the back waits for it to
// be taken before delivering the next one.
// reset clears the valid bits, rights row valid bits, queue and model
// (bell-lapadula); no clearing pass is needed.
module access_policy_checker_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [apc_pkg::MODEL_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_op,
  input  logic [apc_pkg::IDX_W-1:0]           in_subject_index,
  input  logic [apc_pkg::IDX_W-1:0]           in_object_index,
  input  logic                                in_is_write,
  input  logic [apc_pkg::LEVEL_BITS-1:0]      in_level,
  input  logic [apc_pkg::CATEGORY_BITS-1:0]   in_categories,
  input  logic [apc_pkg::NAME_W-1:0]          in_company,
  input  logic [apc_pkg::NAME_W-1:0]          in_conflict_class,
  input  logic [1:0]                          in_rights,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_allowed,
  output logic                                out_dac_ok,
  output logic                                out_blp_ok,
  output logic                                out_biba_ok,
  output logic                                out_wall_ok,
  output logic                                out_status,
  output logic [1:0]                          out_conflict_kind,
  output logic [apc_pkg::IDX_W-1:0]           out_conflict_object,
  output logic                                out_level_lowered,
  output logic [apc_pkg::LEVEL_BITS-1:0]      out_subject_level_now
);

  logic           q_full, q_push, q_pop, q_valid;
  apc_pkg::item_t push_item, pop_item;

  // accept and classify
  apc_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_subject_index  (in_subject_index),
    .in_object_index   (in_object_index),
    .in_is_write       (in_is_write),
    .in_level          (in_level),
    .in_categories     (in_categories),
    .in_company        (in_company),
    .in_conflict_class (in_conflict_class),
    .in_rights         (in_rights),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (push_item)
  );

  // queue between front and back
  apc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  // checks and writeback
  apc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .q_valid               (q_valid),
    .q_item                (pop_item),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_allowed           (out_allowed),
    .out_dac_ok            (out_dac_ok),
    .out_blp_ok            (out_blp_ok),
    .out_biba_ok           (out_biba_ok),
    .out_wall_ok           (out_wall_ok),
    .out_status            (out_status),
    .out_conflict_kind     (out_conflict_kind),
    .out_conflict_object   (out_conflict_object),
    .out_level_lowered     (out_level_lowered),
    .out_subject_level_now (out_subject_level_now)
  );

endmodule

[tb/access_policy_checker_unit_test.sv]
`timescale 1ns / 1ps

module access_policy_checker_unit_test;

  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  subj;
    logic [5:0]  obj;
    logic        wr;
    logic [7:0]  level;
    logic [31:0] cats;
    logic [7:0]  company;
    logic [7:0]  cls;
    logic [1:0]  rights;
  } access_item_t;

  typedef struct {
    logic       allowed;
    logic       dac_ok;
    logic       blp_ok;
    logic       biba_ok;
    logic       wall_ok;
    logic       status;
    logic [1:0] kind;
    logic [5:0] cobj;
    logic       lowered;
    logic [7:0] lvl_now;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [apc_pkg::MODEL_W-1:0] cfg_wdata;
  logic in_valid, in_ready;
  logic [1:0] in_op;
  logic [5:0] in_subject_index, in_object_index;
  logic in_is_write;
  logic [7:0] in_level;
  logic [31:0] in_categories;
  logic [7:0] in_company, in_conflict_class;
  logic [1:0] in_rights;
  logic out_valid, out_ready;
  logic out_allowed, out_dac_ok, out_blp_ok, out_biba_ok, out_wall_ok, out_status;
  logic [1:0] out_conflict_kind;
  logic [5:0] out_conflict_object;
  logic out_level_lowered;
  logic [7:0] out_subject_level_now;

  access_policy_checker_unit uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_subject_index(in_subject_index), .in_object_index(in_object_index),
    .in_is_write(in_is_write), .in_level(in_level), .in_categories(in_categories),
    .in_company(in_company), .in_conflict_class(in_conflict_class),
    .in_rights(in_rights), .out_valid(out_valid), .out_ready(out_ready),
    .out_allowed(out_allowed), .out_dac_ok(out_dac_ok), .out_blp_ok(out_blp_ok),
    .out_biba_ok(out_biba_ok), .out_wall_ok(out_wall_ok), .out_status(out_status),
    .out_conflict_kind(out_conflict_kind), .out_conflict_object(out_conflict_object),
    .out_level_lowered(out_level_lowered), .out_subject_level_now(out_subject_level_now)
  );

  // shadow copy of the monitor state
  logic [2:0]  cur_model;
  logic [7:0]  s_level [64];
  logic [31:0] s_cats  [64];
  logic [63:0] s_hist  [64];
  logic        s_valid [64];
  logic [7:0]  o_level [64];
  logic [31:0] o_cats  [64];
  logic [7:0]  o_comp  [64];
  logic [7:0]  o_cls   [64];
  logic        o_valid [64];
  logic [1:0]  rights_cell [64][64];

  verdict_t pending_verdicts[$];
  int mismatch_count;
  int result_count;
  int burst_left;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic dom(logic [7:0] la, logic [31:0] ca,
                               logic [7:0] lb, logic [31:0] cb);
    return (la >= lb) && ((ca & cb) == cb);
  endfunction

  function automatic logic read_counts(int s, int j);
    return s_hist[s][j] && o_valid[j] && (o_cls[j] != 8'd0);
  endfunction

  // compute the verdict for one item and update the shadow state
  function automatic verdict_t judge_access(access_item_t it);
    verdict_t v;
    int s, o;
    logic use_blp, use_biba, use_lwm, use_wall, mac, all;
    logic [7:0] sl, ol;
    logic [31:0] sc, oc;
    s = int'(it.subj);
    o = int'(it.obj);
    v = '{default: '0};
    use_blp  = (cur_model == apc_pkg::MODEL_BLP) || (cur_model == apc_pkg::MODEL_BLP_BIBA);
    use_biba = (cur_model == apc_pkg::MODEL_BIBA) || (cur_model == apc_pkg::MODEL_BLP_BIBA) ||
               (cur_model == apc_pkg::MODEL_LWM);
    use_lwm  = (cur_model == apc_pkg::MODEL_LWM);
    use_wall = (cur_model == apc_pkg::MODEL_WALL);
    case (it.op)
      apc_pkg::OP_LOAD_SUBJ: begin
        s_level[s] = it.level;
        s_cats[s]  = it.cats;
        s_hist[s]  = '0;
        s_valid[s] = 1'b1;
      end
      apc_pkg::OP_LOAD_OBJ: begin
        o_level[o] = it.level;
        o_cats[o]  = it.cats;
        o_comp[o]  = it.company;
        o_cls[o]   = it.cls;
        o_valid[o] = 1'b1;
      end
      apc_pkg::OP_RIGHTS: begin
        if (s_valid[s] && o_valid[o]) rights_cell[s][o] |= it.rights;
        else v.status = 1'b1;
      end
      default: begin
        if (!(s_valid[s] && o_valid[o])) begin
          v.status = 1'b1;
        end else begin
          sl = s_level[s]; sc = s_cats[s]; ol = o_level[o]; oc = o_cats[o];
          v.dac_ok  = (rights_cell[s][o] &
                       (it.wr ? apc_pkg::RIGHT_WRITE : apc_pkg::RIGHT_READ)) != 2'b00;
          v.blp_ok  = it.wr ? dom(ol, oc, sl, sc) : dom(sl, sc, ol, oc);
          v.biba_ok = it.wr ? dom(sl, sc, ol, oc) : dom(ol, oc, sl, sc);
          v.wall_ok = 1'b1;
          if (use_lwm && !it.wr) v.biba_ok = 1'b1;
          if (use_wall) begin
            if (o_cls[o] != 8'd0) begin
              for (int j = 0; j < 64 && v.wall_ok; j++) begin
                if (read_counts(s, j) && o_cls[j] == o_cls[o] && o_comp[j] != o_comp[o]) begin
                  v.wall_ok = 1'b0; v.kind = apc_pkg::KIND_CLASS; v.cobj = 6'(j);
                end
              end
            end
            if (v.wall_ok && it.wr) begin
              for (int j = 0; j < 64 && v.wall_ok; j++) begin
                if (read_counts(s, j) && o_comp[j] != o_comp[o]) begin
                  v.wall_ok = 1'b0; v.kind = apc_pkg::KIND_LEAK; v.cobj = 6'(j);
                end
              end
            end
          end
          mac = 1'b1;
          if (use_blp) mac = mac && v.blp_ok;
          if (use_biba) mac = mac && v.biba_ok;
          if (use_wall) mac = mac && v.wall_ok;
          all = v.dac_ok && mac;
          if (all && use_lwm && !it.wr && !dom(ol, oc, sl, sc)) begin
            s_level[s] = (sl < ol) ? sl : ol;
            s_cats[s]  = sc & oc;
            v.lowered  = 1'b1;
          end
          if (all && use_wall && !it.wr) s_hist[s][o] = 1'b1;
          v.allowed = all;
        end
      end
    endcase
    v.lvl_now = s_valid[s] ? s_level[s] : 8'd0;
    return v;
  endfunction

  // send one item, with burst and gap pacing
  task automatic send_item(access_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 30))
                                        : int'($urandom_range(0, 2));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_op             <= it.op;
    in_subject_index  <= it.subj;
    in_object_index   <= it.obj;
    in_is_write       <= it.wr;
    in_level          <= it.level;
    in_categories     <= it.cats;
    in_company        <= it.company;
    in_conflict_class <= it.cls;
    in_rights         <= it.rights;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_verdicts.push_back(judge_access(it));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_model(logic [2:0] m);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (m <= apc_pkg::MODEL_WALL) cur_model = m;
  endtask

  function automatic access_item_t mk(logic [1:0] op, int s, int o, logic wr,
                                      logic [7:0] lv, logic [31:0] c,
                                      logic [7:0] comp, logic [7:0] cls,
                                      logic [1:0] r);
    access_item_t it;
    it.op = op; it.subj = 6'(s); it.obj = 6'(o); it.wr = wr; it.level = lv; it.cats = c;
    it.company = comp; it.cls = cls; it.rights = r;
    return it;
  endfunction

  // random item biased toward a small working set so checks get deep
  function automatic access_item_t rand_item(int span);
    access_item_t it;
    int k;
    k = $urandom_range(0, 99);
    it.op = (k < 10) ? apc_pkg::OP_LOAD_SUBJ : (k < 22) ? apc_pkg::OP_LOAD_OBJ :
            (k < 40) ? apc_pkg::OP_RIGHTS : apc_pkg::OP_REQUEST;
    it.subj = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, span));
    it.obj  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, span));
    it.wr = 1'($urandom_range(0, 1));
    it.level = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
    it.cats = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 15));
    it.company = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
    it.cls = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 2));
    it.rights = 2'($urandom_range(0, 3));
    return it;
  endfunction

  // result checker with its own stall pattern
  always @(posedge clk) begin
    verdict_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (pending_verdicts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result item at %0t", $realtime);
        end else begin
          e = pending_verdicts.pop_front();
          if (e.allowed !== out_allowed || e.dac_ok !== out_dac_ok ||
              e.blp_ok !== out_blp_ok || e.biba_ok !== out_biba_ok ||
              e.wall_ok !== out_wall_ok || e.status !== out_status ||
              e.kind !== out_conflict_kind || e.cobj !== out_conflict_object ||
              e.lowered !== out_level_lowered || e.lvl_now !== out_subject_level_now) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch #%0d exp a%b d%b p%b b%b w%b s%b k%0d o%0d l%b n%0d",
                        " got a%b d%b p%b b%b w%b s%b k%0d o%0d l%b n%0d"},
                       result_count, e.allowed, e.dac_ok, e.blp_ok, e.biba_ok,
                       e.wall_ok, e.status, e.kind, e.cobj, e.lowered, e.lvl_now,
                       out_allowed, out_dac_ok, out_blp_ok, out_biba_ok, out_wall_ok,
                       out_status, out_conflict_kind, out_conflict_object,
                       out_level_lowered, out_subject_level_now);
          end
        end
      end
      out_ready <= ((result_count / 50) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // directed loads, rights and requests under every model
  task automatic test_directed();
    send_item(mk(apc_pkg::OP_REQUEST, 0, 0, 1'b0, 0, 0, 0, 0, 0));
    send_item(mk(apc_pkg::OP_RIGHTS, 0, 0, 1'b0, 0, 0, 0, 0, apc_pkg::RIGHT_READ));
    send_item(mk(apc_pkg::OP_LOAD_SUBJ, 0, 0, 1'b0, 8'hFF, 32'hFFFFFFFF, 0, 0, 0));
    send_item(mk(apc_pkg::OP_LOAD_SUBJ, 63, 63, 1'b1, 8'h00, 32'h0, 8'hFF, 8'hFF, 3));
    send_item(mk(apc_pkg::OP_LOAD_OBJ, 0, 0, 1'b0, 8'h10, 32'h0000000F, 8'd1, 8'd1, 0));
    send_item(mk(apc_pkg::OP_LOAD_OBJ, 0, 1, 1'b0, 8'h20, 32'h000000F0, 8'd2, 8'd1, 0));
    send_item(mk(apc_pkg::OP_LOAD_OBJ, 0, 63, 1'b0, 8'hFF, 32'hFFFFFFFF, 8'hFF, 8'd0, 0));
    send_item(mk(apc_pkg::OP_RIGHTS, 0, 0, 1'b0, 0, 0, 0, 0, apc_pkg::RIGHT_READ));
    send_item(mk(apc_pkg::OP_RIGHTS, 0, 1, 1'b0, 0, 0, 0, 0, 2'b11));
    send_item(mk(apc_pkg::OP_RIGHTS, 0, 63, 1'b0, 0, 0, 0, 0, apc_pkg::RIGHT_WRITE));
    send_item(mk(apc_pkg::OP_RIGHTS, 63, 0, 1'b0, 0, 0, 0, 0, 2'b11));
    send_item(mk(apc_pkg::OP_RIGHTS, 5, 0, 1'b0, 0, 0, 0, 0, 2'b11));
    for (int m = 0; m <= 4; m++) begin
      set_model(3'(m));
      send_item(mk(apc_pkg::OP_REQUEST, 0, 0, 1'b0, 0, 0, 0, 0, 0));
      send_item(mk(apc_pkg::OP_REQUEST, 0, 1, 1'b1, 0, 0, 0, 0, 0));
      send_item(mk(apc_pkg::OP_REQUEST, 0, 63, 1'b1, 0, 0, 0, 0, 0));
      send_item(mk(apc_pkg::OP_REQUEST, 63, 0, 1'b0, 0, 0, 0, 0, 0));
      send_item(mk(apc_pkg::OP_REQUEST, 0, 1, 1'b0, 0, 0, 0, 0, 0));
    end
    // an out-of-range model code must be ignored
    set_model(3'd7);
    send_item(mk(apc_pkg::OP_REQUEST, 63, 0, 1'b1, 0, 0, 0, 0, 0));
  endtask

  // random items across model phases
  task automatic test_random();
    logic [2:0] phases[7];
    phases = '{apc_pkg::MODEL_WALL, apc_pkg::MODEL_LWM, apc_pkg::MODEL_BLP,
               apc_pkg::MODEL_BIBA, apc_pkg::MODEL_BLP_BIBA, apc_pkg::MODEL_WALL, 3'd5};
    for (int p = 0; p < 7; p++) begin
      set_model(phases[p]);
      for (int i = 0; i < 200; i++) begin
        send_item(rand_item((i < 100) ? 7 : 63));
        if (i == 120) begin
          // let the queue run dry before going on
          in_valid <= 1'b0;
          while (pending_verdicts.size() != 0) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_op = '0;
    in_subject_index = '0;
    in_object_index = '0;
    in_is_write = 1'b0;
    in_level = '0;
    in_categories = '0;
    in_company = '0;
    in_conflict_class = '0;
    in_rights = '0;
    mismatch_count = 0;
    result_count = 0;
    burst_left = 0;
    cur_model = apc_pkg::MODEL_BLP;
    for (int i = 0; i < 64; i++) begin
      s_valid[i] = 1'b0; o_valid[i] = 1'b0; s_hist[i] = '0;
      s_level[i] = '0; s_cats[i] = '0; o_level[i] = '0; o_cats[i] = '0;
      o_comp[i] = '0; o_cls[i] = '0;
      for (int j = 0; j < 64; j++) rights_cell[i][j] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    wait_idle();
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
